>>> rtl/cbpt_pkg.sv
// Shared constants, types and helpers for the cubic Bezier path timer.
`timescale 1ns / 1ps

package cbpt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int TIME_WIDTH  = 24;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COORD = 4;
  localparam int NUM_POINT = 4;

  // curve parameter t is unsigned Q1.16, weights are Q1.32 up to and including 1.0
  localparam int FRAC_W = 16;
  localparam int T_W    = FRAC_W + 1;
  localparam int WGT_W  = 2 * FRAC_W + 1;

  // shared signed multiplier: a carries t, u, squares and weights, b carries t, u or a coordinate
  localparam int MUL_A_W = WGT_W + 1;
  localparam int MUL_B_W = ((COORD_WIDTH > T_W) ? COORD_WIDTH : T_W) + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = COORD_WIDTH + WGT_W + 3;

  localparam int IN_TDATA_W  = ((TIME_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_COORD * COORD_WIDTH + 7) / 8) * 8;

  localparam int MAC_ISSUES = NUM_COORD * NUM_POINT;
  localparam int CNT_MAX    = (MAC_ISSUES > FRAC_W) ? MAC_ISSUES : FRAC_W;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam int WGT_OPS    = 5;

  localparam logic [TIME_WIDTH-1:0] DUR_RESET = TIME_WIDTH'(1000);
  localparam logic [T_W-1:0]        T_ONE     = T_W'(1) << FRAC_W;
  localparam logic [WGT_W-1:0]      W_ONE     = WGT_W'(1) << (2 * FRAC_W);
  localparam logic [ACC_W-1:0]      ROUND_C   = ACC_W'(1) << (2 * FRAC_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_A  = 3'd0,
    REG_POINT_B  = 3'd1,
    REG_POINT_C  = 3'd2,
    REG_POINT_D  = 3'd3,
    REG_DURATION = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_UU,
    OP_TT,
    OP_W1,
    OP_W2,
    OP_W3
  } wgt_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TU,
    ST_WGT,
    ST_W0,
    ST_MAC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        load_time;
    logic        div_step;
    logic        set_tu;
    logic        wgt_en;
    wgt_op_e     wgt_op;
    logic        set_w0;
    logic        mac_issue;
    logic [1:0]  mac_k;
    logic [1:0]  mac_i;
    logic        out_load;
  } cmd_t;

  // coordinate k of a packed control point; one lying wholly above the word reads as zero
  function automatic logic signed [COORD_WIDTH-1:0] coord_of(logic [CFG_W-1:0] pt,
                                                             logic [1:0] k);
    int unsigned       sh;
    logic [CFG_W-1:0]  v;
    sh = int'(k) * COORD_WIDTH;
    v  = pt >> sh;
    if (sh >= CFG_W) begin
      return '0;
    end
    return signed'(v[COORD_WIDTH-1:0]);
  endfunction

endpackage

>>> rtl/cbpt_ctrl.sv
// Sequencer for the path timer: time update, divide, weights, multiply-accumulate.
`timescale 1ns / 1ps

module cbpt_ctrl import cbpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_busy_i,
  output cmd_t cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CNT_W'(1);
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(FRAC_W - 1)) begin
          state_d = ST_TU;
        end
      end
      ST_TU: begin
        cnt_d   = '0;
        state_d = ST_WGT;
      end
      ST_WGT: begin
        if (cnt_q == CNT_W'(WGT_OPS - 1)) begin
          state_d = ST_W0;
        end
      end
      ST_W0: begin
        cnt_d   = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        // the last count issues no product and lets the last product drain
        if (cnt_q == CNT_W'(MAC_ISSUES)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cnt_d = '0;
        if (!out_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_time = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_TU: begin
        cmd_o.set_tu = 1'b1;
      end
      ST_WGT: begin
        cmd_o.wgt_en = 1'b1;
        case (cnt_q[2:0])
          3'd0:    cmd_o.wgt_op = OP_UU;
          3'd1:    cmd_o.wgt_op = OP_TT;
          3'd2:    cmd_o.wgt_op = OP_W1;
          3'd3:    cmd_o.wgt_op = OP_W2;
          default: cmd_o.wgt_op = OP_W3;
        endcase
      end
      ST_W0: begin
        cmd_o.set_w0 = 1'b1;
      end
      ST_MAC: begin
        cmd_o.mac_issue = (cnt_q < CNT_W'(MAC_ISSUES));
        cmd_o.mac_k     = cnt_q[3:2];
        cmd_o.mac_i     = cnt_q[1:0];
      end
      ST_OUT: begin
        cmd_o.out_load = !out_busy_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/cbpt_datapath.sv
// Datapath: config registers, elapsed time, serial divider, shared multiplier, output register.
`timescale 1ns / 1ps

module cbpt_datapath import cbpt_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [CFG_W-1:0]                cfg_data_i,
  input  logic                            restart_i,
  input  logic [TIME_WIDTH-1:0]           step_ticks_i,
  input  cmd_t                            cmd_i,
  output logic                            out_busy_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [NUM_COORD*COORD_WIDTH-1:0] out_pos_o,
  output logic                            out_finished_o
);

  logic [CFG_W-1:0]      point_q [NUM_POINT];
  logic [TIME_WIDTH-1:0] dur_q;
  logic [TIME_WIDTH-1:0] elapsed_q;
  logic                  done_q;

  logic [TIME_WIDTH-1:0] rem_q;
  logic [FRAC_W-1:0]     quot_q;
  logic [T_W-1:0]        t_q, u_q;
  logic [WGT_W-1:0]      uu_q, tt_q;
  logic [WGT_W-1:0]      w_q [NUM_POINT];

  logic signed [MUL_P_W-1:0] prod_q;
  logic                      prod_vld_q;
  logic [1:0]                prod_k_q, prod_i_q;
  logic [ACC_W-1:0]          acc_q;
  logic [COORD_WIDTH-1:0]    pos_q [NUM_COORD];

  logic [NUM_COORD*COORD_WIDTH-1:0] out_pos_q;
  logic                             out_fin_q;
  logic                             out_valid_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_POINT; p++) begin
        point_q[p] <= '0;
      end
      dur_q <= DUR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POINT_A:  point_q[0] <= cfg_data_i;
        REG_POINT_B:  point_q[1] <= cfg_data_i;
        REG_POINT_C:  point_q[2] <= cfg_data_i;
        REG_POINT_D:  point_q[3] <= cfg_data_i;
        REG_DURATION: dur_q      <= cfg_data_i[TIME_WIDTH-1:0];
        default:      ;
      endcase
    end
  end

  // elapsed time: add step (from zero on restart), saturate at duration
  logic [TIME_WIDTH:0]   time_sum;
  logic [TIME_WIDTH-1:0] elapsed_d;

  always_comb begin
    time_sum = (restart_i ? '0 : {1'b0, elapsed_q}) + {1'b0, step_ticks_i};
    if (time_sum > {1'b0, dur_q}) begin
      elapsed_d = dur_q;
    end else begin
      elapsed_d = time_sum[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
    end else if (cmd_i.load_time) begin
      elapsed_q <= elapsed_d;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [TIME_WIDTH:0] rem_dbl;
  logic                rem_ge;

  assign rem_dbl = {rem_q, 1'b0};
  assign rem_ge  = (rem_dbl >= {1'b0, dur_q});

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W+1:0]        triple_p;
  logic [WGT_W-1:0]          wgt_shift;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mac_issue) begin
      mul_a = signed'({1'b0, w_q[cmd_i.mac_i]});
      mul_b = MUL_B_W'(coord_of(point_q[cmd_i.mac_i], cmd_i.mac_k));
    end else begin
      case (cmd_i.wgt_op)
        OP_UU: begin
          mul_a = signed'(MUL_A_W'(u_q));
          mul_b = signed'(MUL_B_W'(u_q));
        end
        OP_TT: begin
          mul_a = signed'(MUL_A_W'(t_q));
          mul_b = signed'(MUL_B_W'(t_q));
        end
        OP_W1: begin
          mul_a = signed'({1'b0, uu_q});
          mul_b = signed'(MUL_B_W'(t_q));
        end
        OP_W2: begin
          mul_a = signed'({1'b0, tt_q});
          mul_b = signed'(MUL_B_W'(u_q));
        end
        OP_W3: begin
          mul_a = signed'({1'b0, tt_q});
          mul_b = signed'(MUL_B_W'(t_q));
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p     = mul_a * mul_b;
  assign triple_p  = {2'b00, mul_p} + {1'b0, mul_p, 1'b0};
  assign wgt_shift = (cmd_i.wgt_op == OP_W3) ? mul_p[FRAC_W +: WGT_W]
                                             : triple_p[FRAC_W +: WGT_W];

  // accumulate rounding term, sum of four products, take the integer part
  logic [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0] acc_sum;

  assign prod_ext = ACC_W'(prod_q);
  assign acc_sum  = acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_time) begin
      done_q <= (elapsed_d >= dur_q);
      rem_q  <= elapsed_d;
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? TIME_WIDTH'(rem_dbl - {1'b0, dur_q}) : rem_dbl[TIME_WIDTH-1:0];
      quot_q <= {quot_q[FRAC_W-2:0], rem_ge};
    end
    if (cmd_i.set_tu) begin
      t_q <= done_q ? T_ONE : {1'b0, quot_q};
      u_q <= T_ONE - (done_q ? T_ONE : {1'b0, quot_q});
    end
    if (cmd_i.wgt_en) begin
      case (cmd_i.wgt_op)
        OP_UU:   uu_q   <= mul_p[WGT_W-1:0];
        OP_TT:   tt_q   <= mul_p[WGT_W-1:0];
        OP_W1:   w_q[1] <= wgt_shift;
        OP_W2:   w_q[2] <= wgt_shift;
        OP_W3:   w_q[3] <= wgt_shift;
        default: ;
      endcase
    end
    if (cmd_i.set_w0) begin
      w_q[0] <= WGT_W'(W_ONE - (w_q[1] + w_q[2] + w_q[3]));
    end
    if (cmd_i.mac_issue) begin
      prod_q   <= mul_p;
      prod_k_q <= cmd_i.mac_k;
      prod_i_q <= cmd_i.mac_i;
    end
    if (prod_vld_q) begin
      if (prod_i_q == 2'd0) begin
        acc_q <= prod_ext + ROUND_C;
      end else if (prod_i_q == 2'(NUM_POINT - 1)) begin
        pos_q[prod_k_q] <= acc_sum[2*FRAC_W +: COORD_WIDTH];
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (cmd_i.out_load) begin
      for (int k = 0; k < NUM_COORD; k++) begin
        out_pos_q[k*COORD_WIDTH +: COORD_WIDTH] <= pos_q[k];
      end
      out_fin_q <= done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_busy_o     = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_pos_o      = out_pos_q;
  assign out_finished_o = out_fin_q;

endmodule

>>> rtl/cubic_bezier_path_timer.sv
// Top level of the cubic Bezier path timer: controller plus datapath.
//
//  channel   | direction | fields (low bit first)                     | accepted when
//  ----------+-----------+--------------------------------------------+----------------------
//  s_axis    | in        | tdata: step_ticks; tuser: restart          | tvalid && tready
//  m_axis    | out       | tdata: pos_x,pos_y,pos_z,pos_w; tuser: fin | tvalid && tready
//  cfg       | in        | index: register, data: value               | cfg_we_i
//
// A request is accepted in idle, where elapsed time is updated; its result then passes the restoring
// divider, t, u and the weights on the shared multiplier, and the multiply-accumulate of four points
// by four coordinates, and is loaded into the output register once that register is free.
// A new request is taken only after the previous result has been loaded.
// The multiplier is the one shared unit; the divider yields one quotient bit a cycle.
// A finished result waits in the output register while the next item is accepted and worked.
// Reset clears elapsed time, control points (to 0) and duration (to 1000).
`timescale 1ns / 1ps

module cubic_bezier_path_timer import cbpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // step_ticks
  input  logic [0:0]             s_axis_tuser,   // restart
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pos_x, pos_y, pos_z, pos_w
  output logic [0:0]             m_axis_tuser    // finished
);

  cmd_t                             cmd;
  logic                             out_busy;
  logic [NUM_COORD*COORD_WIDTH-1:0] out_pos;
  logic                             out_finished;

  cbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (out_busy),
    .cmd_o      (cmd)
  );

  cbpt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .restart_i      (s_axis_tuser[0]),
    .step_ticks_i   (s_axis_tdata[TIME_WIDTH-1:0]),
    .cmd_i          (cmd),
    .out_busy_o     (out_busy),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_pos_o      (out_pos),
    .out_finished_o (out_finished)
  );

  assign m_axis_tdata    = OUT_TDATA_W'(out_pos);
  assign m_axis_tuser[0] = out_finished;

endmodule

>>> sim/tb_cubic_bezier_path_timer.sv
// Self-checking testbench for the cubic Bezier path timer: directed and random timing requests.
`timescale 1ns / 1ps

module tb_cubic_bezier_path_timer;
  import cbpt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_LEN   = 7;
  localparam int NUM_REGS    = int'(REG_DURATION) + 1;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int LIMIT       = 1_000_000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_REQS  = 108;
  localparam int MAX_REPORTS = 10;

  localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = ~COORD_MIN;
  localparam logic [COORD_WIDTH-1:0] COORD_NEG = '1;
  localparam longint unsigned        ONE_Q16   = 64'd1 << FRAC_W;

  typedef struct packed {
    logic                                  restart;
    logic [TIME_WIDTH-1:0]                 step;
  } path_req_t;

  typedef struct packed {
    logic                                  finished;
    logic [NUM_COORD-1:0][COORD_WIDTH-1:0] pos;
  } pose_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // step_ticks
  logic [0:0]             s_axis_tuser  = '0;   // restart
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // pos_x, pos_y, pos_z, pos_w
  logic [0:0]             m_axis_tuser;         // finished

  // predictor copy of the block's registers and elapsed time
  logic [CFG_W-1:0]      ctrl_point [NUM_POINT];
  logic [TIME_WIDTH-1:0] path_duration;
  logic [TIME_WIDTH-1:0] path_elapsed;

  path_req_t   request_q [$];
  pose_t       pose_q [$];
  pose_t       want_pose;
  cfg_idx_e    point_reg [NUM_POINT] = '{REG_POINT_A, REG_POINT_B, REG_POINT_C, REG_POINT_D};
  int          mismatches    = 0;
  bit          idle_on       = 1'b1;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          send_gap      = 0;
  int          stall_left    = 0;
  int          ready_gap;
  int unsigned cycle_count   = 0;

  cubic_bezier_path_timer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // advance elapsed time by one request and form the expected curve point
  function automatic pose_t advance_path(logic restart, logic [TIME_WIDTH-1:0] step);
    longint unsigned total, t, u;
    longint unsigned wgt [NUM_POINT];
    longint          c, acc, rnd;
    logic [CFG_W-1:0] pt;
    pose_t           res;
    total = (restart ? 64'd0 : 64'(path_elapsed)) + 64'(step);
    if (total > 64'(path_duration)) begin
      total = 64'(path_duration);
    end
    path_elapsed = total[TIME_WIDTH-1:0];
    res.finished = (total >= 64'(path_duration));
    t = res.finished ? ONE_Q16 : (total << FRAC_W) / 64'(path_duration);
    u = ONE_Q16 - t;
    wgt[1] = (64'd3 * u * u * t) >> FRAC_W;
    wgt[2] = (64'd3 * u * t * t) >> FRAC_W;
    wgt[3] = (t * t * t) >> FRAC_W;
    // first weight takes up the truncation so the four sum to exactly one
    wgt[0] = (64'd1 << (2 * FRAC_W)) - (wgt[1] + wgt[2] + wgt[3]);
    for (int k = 0; k < NUM_COORD; k++) begin
      acc = 0;
      for (int i = 0; i < NUM_POINT; i++) begin
        pt  = ctrl_point[i];
        c   = $signed(pt[k*COORD_WIDTH +: COORD_WIDTH]);
        acc = acc + c * longint'(wgt[i]);
      end
      rnd = (acc + (longint'(1) <<< (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
      res.pos[k] = rnd[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  function automatic int rand_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 4);
    end
    if (r < 98) begin
      return $urandom_range(5, 16);
    end
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [CFG_W-1:0] rand_point();
    logic [CFG_W-1:0] pt;
    pt = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) begin
      return pt;
    end
    // mix in coordinate extremes
    for (int k = 0; k < NUM_COORD; k++) begin
      case ($urandom_range(0, 4))
        0: pt[k*COORD_WIDTH +: COORD_WIDTH] = COORD_MIN;
        1: pt[k*COORD_WIDTH +: COORD_WIDTH] = COORD_MAX;
        2: pt[k*COORD_WIDTH +: COORD_WIDTH] = '0;
        3: pt[k*COORD_WIDTH +: COORD_WIDTH] = COORD_NEG;
        default: ;
      endcase
    end
    return pt;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] rand_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TIME_MAX;
      2, 3, 4: return TIME_WIDTH'($urandom_range(1, 64));
      5, 6, 7: return TIME_WIDTH'($urandom_range(100, 5000));
      default: return TIME_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_WIDTH-1:0] step_near(logic [TIME_WIDTH-1:0] base);
    if (base == 0) begin
      return TIME_WIDTH'($urandom_range(0, 1));
    end
    return base - base / 8 + TIME_WIDTH'($urandom_range(0, base / 4));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_POINT_A:  ctrl_point[0] = val;
      REG_POINT_B:  ctrl_point[1] = val;
      REG_POINT_C:  ctrl_point[2] = val;
      REG_POINT_D:  ctrl_point[3] = val;
      REG_DURATION: path_duration = val[TIME_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic push_req(logic restart, logic [TIME_WIDTH-1:0] step);
    path_req_t req;
    req.restart = restart;
    req.step    = step;
    request_q.push_back(req);
  endtask

  // hold off until every request is accepted and answered
  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (request_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0);
  endtask

  // mostly restart-led runs that sweep t across the duration, some noise between
  task automatic queue_path(int n);
    int                    left;
    int                    span;
    logic [TIME_WIDTH-1:0] base;
    left = 0;
    base = '0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_req(1'($urandom_range(0, 1)), TIME_WIDTH'($urandom));
      end else if (left == 0) begin
        span = $urandom_range(2, 24);
        left = span + 2;
        base = path_duration / TIME_WIDTH'(span);
        push_req(1'b1, step_near(base));
      end else begin
        left--;
        push_req(1'b0, step_near(base));
      end
    end
  endtask

  task automatic note_mismatch(string what, int expv, int got);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", what, expv, got);
    end
    mismatches++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pose_q.push_back(advance_path(s_axis_tuser[0], s_axis_tdata[TIME_WIDTH-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_TDATA_W'(request_q[0].step);
          s_axis_tuser  <= request_q[0].restart;
          void'(request_q.pop_front());
          send_gap      <= rand_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pose_q.size() == 0) begin
          note_mismatch("result without a pending request", 0, 1);
        end else begin
          want_pose = pose_q.pop_front();
          for (int k = 0; k < NUM_COORD; k++) begin
            if (m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH] !== want_pose.pos[k]) begin
              note_mismatch($sformatf("coordinate %0d", k), $signed(want_pose.pos[k]),
                            $signed(m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH]));
            end
          end
          if (m_axis_tuser[0] !== want_pose.finished) begin
            note_mismatch("finished", want_pose.finished, m_axis_tuser[0]);
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served  <= holds_served + 1;
        stall_left    <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        ready_gap      = rand_gap();
        m_axis_tready <= (ready_gap == 0);
        stall_left    <= (ready_gap == 0) ? 0 : ready_gap - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [TIME_WIDTH-1:0] dur;
    foreach (ctrl_point[i]) begin
      ctrl_point[i] = '0;
    end
    path_duration = DUR_RESET;
    path_elapsed  = '0;
    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: all points at the origin, duration 1000
    push_req(1'b0, '0);
    push_req(1'b0, TIME_WIDTH'(500));
    drain();

    write_reg(REG_POINT_A, {COORD_MAX, COORD_NEG, {COORD_WIDTH{1'b0}}, COORD_MIN});
    write_reg(REG_POINT_B, {COORD_MIN, COORD_MAX, COORD_WIDTH'(1), COORD_MAX});
    write_reg(REG_POINT_C, {COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN});
    write_reg(REG_POINT_D, {COORD_MAX, COORD_MIN, COORD_NEG, {COORD_WIDTH{1'b0}}});
    push_req(1'b1, '0);
    push_req(1'b0, TIME_WIDTH'(250));
    push_req(1'b0, TIME_WIDTH'(249));
    push_req(1'b0, TIME_WIDTH'(250));
    push_req(1'b0, TIME_WIDTH'(250));
    push_req(1'b0, TIME_WIDTH'(1));
    push_req(1'b0, TIME_MAX);
    push_req(1'b1, TIME_WIDTH'(999));
    drain();

    // zero duration pins the curve to its end point
    write_reg(REG_DURATION, '0);
    push_req(1'b0, '0);
    push_req(1'b1, TIME_MAX);
    push_req(1'b0, TIME_WIDTH'(7));
    drain();

    // longest duration; the step sum carries past the counter width
    write_reg(REG_DURATION, CFG_W'(TIME_MAX));
    push_req(1'b1, TIME_MAX - 1);
    push_req(1'b0, TIME_MAX);
    push_req(1'b1, TIME_WIDTH'(1));
    push_req(1'b0, TIME_WIDTH'(24'h800000));
    drain();

    // shorten below elapsed time, then lengthen again
    write_reg(REG_DURATION, CFG_W'(100));
    push_req(1'b0, '0);
    drain();
    write_reg(REG_DURATION, CFG_W'(5000));
    push_req(1'b0, '0);
    push_req(1'b0, TIME_WIDTH'(2500));
    drain();

    // indexes past the register list change nothing
    for (int j = NUM_REGS; j < (1 << CFG_IDX_W); j++) begin
      write_reg(CFG_IDX_W'(j), {$urandom, $urandom});
    end
    push_req(1'b0, TIME_WIDTH'(1));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p % 4) != 1;
      for (int i = 0; i < NUM_POINT; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(point_reg[i], rand_point());
        end
      end
      case (p)
        0:       dur = TIME_WIDTH'(1);
        1:       dur = TIME_MAX;
        2:       dur = '0;
        default: dur = rand_duration();
      endcase
      write_reg(REG_DURATION, CFG_W'(dur));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
      end
      // stall the receiver long enough to back up the block
      if (p == 3) begin
        hold_requests++;
      end
      queue_path(PHASE_REQS);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
